// ----- src/hndm_pkg.sv -----
// Shared constants, codes and controller/datapath types for the Hamming
// nearest descriptor matcher. No dependencies.
`timescale 1ns / 1ps

package hndm_pkg;

   localparam int DESC_WORDS_DEF = 8;
   localparam int MAX_REFS_DEF   = 1024;

   localparam int OPCODE_W = 2;
   localparam int WI_W     = 3;
   localparam int WORD_W   = 64;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 10;
   localparam int DIST_W   = 10;
   localparam int POP_W    = 7;

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REF   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                store_clear;
      logic                ref_write;
      logic                count_incr;
      logic                query_write;
      logic                scan_start;
      logic                scan_step;
      logic                load_status;
      logic [STATUS_W-1:0] status;
      logic                load_match;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic scan_last;
      logic pipe_busy;
      logic rsp_pending;
   } dp_stat_type;

   // popcount as a small adder tree: nibbles, groups of four, then total
   function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
      logic [2:0] nib [16];
      logic [4:0] grp [4];
      logic [POP_W-1:0] sum;
      for (int i = 0; i < 16; i++) begin
         nib[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
      end
      for (int g = 0; g < 4; g++) begin
         grp[g] = 5'(nib[4*g]) + 5'(nib[4*g+1]) + 5'(nib[4*g+2]) + 5'(nib[4*g+3]);
      end
      sum = POP_W'(grp[0]) + POP_W'(grp[1]) + POP_W'(grp[2]) + POP_W'(grp[3]);
      return sum;
   endfunction

endpackage

// ----- src/hndm_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on hndm_pkg for field widths.
`timescale 1ns / 1ps

interface hndm_req_if;
   logic                          valid;
   logic                          ready;
   logic [hndm_pkg::OPCODE_W-1:0] opcode;
   logic [hndm_pkg::WI_W-1:0]     word_index;
   logic [hndm_pkg::WORD_W-1:0]   word_bits;

   modport source (output valid, output opcode, output word_index, output word_bits,
                   input ready);
   modport sink   (input valid, input opcode, input word_index, input word_bits,
                   output ready);
endinterface

interface hndm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hndm_pkg::STATUS_W-1:0] status;
   logic [hndm_pkg::IDX_W-1:0]    match_index;
   logic [hndm_pkg::DIST_W-1:0]   match_distance;

   modport source (output valid, output status, output match_index,
                   output match_distance, input ready);
   modport sink   (input valid, input status, input match_index,
                   input match_distance, output ready);
endinterface

// ----- src/hndm_ctrl.sv -----
// Controller: decodes request words and sequences the reference scan.
// Depends on hndm_pkg; drives the datapath through dp_cmd_type.
`timescale 1ns / 1ps

module hndm_ctrl #(
   parameter int DESC_WORDS = hndm_pkg::DESC_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [hndm_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [hndm_pkg::WI_W-1:0]     req_word_index,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   input  hndm_pkg::dp_stat_type         stat,
   output hndm_pkg::dp_cmd_type          cmd
);
   import hndm_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_type;

   state_type  state_ff, state_in;
   logic       fire, wi_ok, last;

   assign req_ready = (state_ff == S_IDLE) && (!stat.rsp_pending || rsp_ready);
   assign fire      = req_valid && req_ready;
   assign wi_ok     = {1'b0, req_word_index} < (WI_W + 1)'(DESC_WORDS);
   assign last      = req_word_index == WI_W'(DESC_WORDS - 1);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               unique case (req_opcode)
                  OP_CLEAR: begin
                     cmd.store_clear = 1'b1;
                  end
                  OP_REF: begin
                     if (wi_ok) begin
                        if (!stat.count_full) begin
                           cmd.ref_write  = 1'b1;
                           cmd.count_incr = last;
                        end else if (last) begin
                           cmd.load_status = 1'b1;
                           cmd.status      = ST_FULL;
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (wi_ok) begin
                        cmd.query_write = 1'b1;
                        if (last) begin
                           if (stat.count_zero) begin
                              cmd.load_status = 1'b1;
                              cmd.status      = ST_EMPTY;
                           end else begin
                              cmd.scan_start = 1'b1;
                              state_in       = S_SCAN;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.load_match = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/hndm_datapath.sv -----
// Datapath: reference banks, query register, distance pipeline, best
// tracker and response register. Depends on hndm_pkg.
`timescale 1ns / 1ps

module hndm_datapath #(
   parameter int DESC_WORDS = hndm_pkg::DESC_WORDS_DEF,
   parameter int MAX_REFS   = hndm_pkg::MAX_REFS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hndm_pkg::WI_W-1:0]     req_word_index,
   input  logic [hndm_pkg::WORD_W-1:0]   req_word_bits,
   input  hndm_pkg::dp_cmd_type          cmd,
   output hndm_pkg::dp_stat_type         stat,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [hndm_pkg::STATUS_W-1:0] rsp_status,
   output logic [hndm_pkg::IDX_W-1:0]    rsp_match_index,
   output logic [hndm_pkg::DIST_W-1:0]   rsp_match_distance
);
   import hndm_pkg::*;

   localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CW = $clog2(MAX_REFS + 1);
   localparam int DW = $clog2(DESC_WORDS * WORD_W + 1);

   logic [CW-1:0]     count_ff;
   logic [AW-1:0]     ptr_ff;
   logic [WORD_W-1:0] rd_q [DESC_WORDS];
   logic [WORD_W-1:0] query_ff [DESC_WORDS];
   logic [POP_W-1:0]  pc_ff [DESC_WORDS];
   logic              va_ff, vb_ff, vc_ff;
   logic [AW-1:0]     idxa_ff, idxb_ff, idxc_ff;
   logic [DW-1:0]     dist_in, distc_ff;
   logic              best_valid_ff;
   logic [AW-1:0]     best_idx_ff;
   logic [DW-1:0]     best_dist_ff;
   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   assign stat.count_zero  = count_ff == '0;
   assign stat.count_full  = count_ff >= CW'(MAX_REFS);
   assign stat.scan_last   = CW'(ptr_ff) == (count_ff - CW'(1));
   assign stat.pipe_busy   = va_ff || vb_ff || vc_ff;
   assign stat.rsp_pending = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.store_clear) begin
         count_ff <= '0;
      end else if (cmd.count_incr) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         ptr_ff <= '0;
      end else if (cmd.scan_step) begin
         ptr_ff <= ptr_ff + AW'(1);
      end
   end

   // one single-port bank per descriptor word, read together during a scan
   for (genvar b = 0; b < DESC_WORDS; b++) begin : g_lane
      logic [WORD_W-1:0] mem [MAX_REFS];

      always_ff @(posedge clock) begin
         if (cmd.ref_write && req_word_index == WI_W'(b)) begin
            mem[count_ff[AW-1:0]] <= req_word_bits;
         end
         if (cmd.scan_step) begin
            rd_q[b] <= mem[ptr_ff];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.query_write && req_word_index == WI_W'(b)) begin
            query_ff[b] <= req_word_bits;
         end
         pc_ff[b] <= pop64(rd_q[b] ^ query_ff[b]);
      end
   end

   always_comb begin
      dist_in = '0;
      for (int b = 0; b < DESC_WORDS; b++) begin
         dist_in = dist_in + DW'(pc_ff[b]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= cmd.scan_step;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      idxa_ff  <= ptr_ff;
      idxb_ff  <= idxa_ff;
      idxc_ff  <= idxb_ff;
      distc_ff <= dist_in;
   end

   // strict less-than keeps the first reference among equal distances
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         best_valid_ff <= 1'b0;
      end else if (vc_ff && (!best_valid_ff || distc_ff < best_dist_ff)) begin
         best_valid_ff <= 1'b1;
      end
      if (vc_ff && (!best_valid_ff || distc_ff < best_dist_ff)) begin
         best_idx_ff  <= idxc_ff;
         best_dist_ff <= distc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_status || cmd.load_match) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_status) begin
         rsp_status_ff <= cmd.status;
         rsp_index_ff  <= '0;
         rsp_dist_ff   <= '0;
      end else if (cmd.load_match) begin
         rsp_status_ff <= ST_MATCH;
         rsp_index_ff  <= IDX_W'(best_idx_ff);
         rsp_dist_ff   <= DIST_W'(best_dist_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_match_index    = rsp_index_ff;
   assign rsp_match_distance = rsp_dist_ff;

endmodule

// ----- src/hamming_nearest_descriptor_match.sv -----
// Brute-force Hamming nearest-neighbor matcher for binary descriptors.
//
// req channel: one 64-bit descriptor word per transfer. Opcode clear empties
// the store; reference words are appended at the current count, the highest
// word index completing a reference; query words fill the query register and
// the highest one starts a scan over all stored references.
// rsp channel: one word for a completed query (index of the first reference
// at minimum distance, and that distance), for a query on an empty store
// (status empty), and for a last reference word dropped on a full store.
// Status-only responses appear the cycle after the request. During a query
// scan one reference per cycle is read from DESC_WORDS single-port banks,
// then a three-stage popcount/sum/compare pipeline drains. A new request is
// taken only once the scan and the drain of the last query have ended.
// req.ready is low during a scan and while a response waits and rsp.ready is
// low; a stalled response holds its value. Reset empties the store at once
// (count to zero, no clearing pass) and drops any pending response.
// Depends on hndm_pkg, hndm_if, hndm_ctrl and hndm_datapath.
`timescale 1ns / 1ps

module hamming_nearest_descriptor_match #(
   parameter int DESC_WORDS = hndm_pkg::DESC_WORDS_DEF,
   parameter int MAX_REFS   = hndm_pkg::MAX_REFS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hndm_req_if.sink    req,
   hndm_rsp_if.source  rsp
);
   import hndm_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   hndm_ctrl #(
      .DESC_WORDS (DESC_WORDS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_opcode     (req.opcode),
      .req_word_index (req.word_index),
      .req_ready      (req.ready),
      .rsp_ready      (rsp.ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   hndm_datapath #(
      .DESC_WORDS (DESC_WORDS),
      .MAX_REFS   (MAX_REFS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_word_index     (req.word_index),
      .req_word_bits      (req.word_bits),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_status         (rsp.status),
      .rsp_match_index    (rsp.match_index),
      .rsp_match_distance (rsp.match_distance)
   );

endmodule

// ----- src/hndm_checker.sv -----
// Port-level checks for the matcher, bound to the top level.
// Depends on hndm_pkg and hamming_nearest_descriptor_match.
`timescale 1ns / 1ps

module hndm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hndm_pkg::STATUS_W-1:0] rsp_status,
   input logic [hndm_pkg::IDX_W-1:0]    rsp_match_index,
   input logic [hndm_pkg::DIST_W-1:0]   rsp_match_distance
);
   import hndm_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_match_index) && $stable(rsp_match_distance))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
         |-> rsp_match_index == '0 && rsp_match_distance == '0)
      else $error("nonzero fields on empty or full status");

   // no new request while a response is stuck
   a_ready_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

endmodule

bind hamming_nearest_descriptor_match hndm_checker u_hndm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_status         (rsp.status),
   .rsp_match_index    (rsp.match_index),
   .rsp_match_distance (rsp.match_distance)
);
